### sv/iidl_pkg.sv
// Shared types and constants for the indexed insert/delete list.
`default_nettype none
package iidl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    ACT_GET    = 3'd0,
    ACT_HEAD   = 3'd1,
    ACT_TAIL   = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_DELETE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       at;
    logic [VAL_W-1:0]       value;
  } cell_cmd_t;

endpackage
`default_nettype wire

### sv/iidl_cells.sv
// Row of entry registers that shift up, shift down or hold.
`default_nettype none
module iidl_cells (
  input  wire logic                          clk,
  input  wire iidl_pkg::cell_cmd_t           cmd,
  input  wire logic [iidl_pkg::IDX_W-1:0]    rd_index,
  output logic      [iidl_pkg::VAL_W-1:0]    rd_data
);

  logic [iidl_pkg::VAL_W-1:0] entries [iidl_pkg::CAPACITY];

  for (genvar g = 0; g < iidl_pkg::CAPACITY; g++) begin : g_cell
    logic [iidl_pkg::VAL_W-1:0] below;
    logic [iidl_pkg::VAL_W-1:0] above;

    if (g == 0) begin : g_first
      assign below = cmd.value;
    end else begin : g_inner_lo
      assign below = entries[g-1];
    end

    // The top cell has no neighbour above; what it holds after a delete is past the count.
    if (g == iidl_pkg::CAPACITY - 1) begin : g_last
      assign above = entries[g];
    end else begin : g_inner_hi
      assign above = entries[g+1];
    end

    always_ff @(posedge clk) begin
      case (cmd.op)
        iidl_pkg::CELL_INSERT: begin
          if (iidl_pkg::IDX_W'(g) > cmd.at) begin
            entries[g] <= below;
          end else if (iidl_pkg::IDX_W'(g) == cmd.at) begin
            entries[g] <= cmd.value;
          end
        end
        iidl_pkg::CELL_DELETE: begin
          if (iidl_pkg::IDX_W'(g) >= cmd.at) begin
            entries[g] <= above;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_data = entries[rd_index];

endmodule
`default_nettype wire

### sv/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list.
`default_nettype none
// Ordered store of up to 64 signed 32-bit entries with a running count. Each item
// requests get, add at head, add at tail, insert before a position or delete at a
// position, and yields exactly one result carrying the value read (zero unless a
// successful get), a status (ok, bad index, full) and the count afterwards. An
// accepted item is held in an input register until its result can be written;
// then every entry register shifts up, shifts down or holds in parallel, and the
// result is written to an output register at the same edge. One item is taken per
// cycle while results are taken. A result left waiting holds the input register,
// which then blocks new items. Unwritten entries are never visible, so there is no
// clearing pass after reset.
module indexed_insert_delete_list (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          action,
  input  wire logic [6:0]          position,
  input  wire logic signed [31:0]  new_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       read_value,
  output logic [1:0]               status,
  output logic [6:0]               length
);

  // Input register
  logic                          s1_valid;
  logic [2:0]                    s1_action;
  logic [6:0]                    s1_position;
  logic [iidl_pkg::VAL_W-1:0]    s1_value;
  logic                          s1_advance;

  logic [iidl_pkg::CNT_W-1:0]    count;
  logic [iidl_pkg::CNT_W-1:0]    count_next;

  iidl_pkg::cell_cmd_t           cmd;
  iidl_pkg::status_t             st_next;
  logic [iidl_pkg::VAL_W-1:0]    rd_data;
  logic [iidl_pkg::VAL_W-1:0]    rd_next;
  logic                          full;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action   <= action;
      s1_position <= position;
      s1_value    <= new_value;
    end
  end

  assign full = (count >= iidl_pkg::CNT_W'(iidl_pkg::CAPACITY));

  always_comb begin
    cmd.op     = iidl_pkg::CELL_HOLD;
    cmd.at     = s1_position[iidl_pkg::IDX_W-1:0];
    cmd.value  = s1_value;
    st_next    = iidl_pkg::ST_OK;
    rd_next    = '0;
    count_next = count;
    case (iidl_pkg::action_t'(s1_action))
      iidl_pkg::ACT_GET: begin
        if (s1_position < count) begin
          rd_next = rd_data;
        end else begin
          st_next = iidl_pkg::ST_BAD_INDEX;
        end
      end
      iidl_pkg::ACT_HEAD: begin
        if (full) begin
          st_next = iidl_pkg::ST_FULL;
        end else begin
          cmd.op     = iidl_pkg::CELL_INSERT;
          cmd.at     = '0;
          count_next = count + 1'b1;
        end
      end
      iidl_pkg::ACT_TAIL: begin
        if (full) begin
          st_next = iidl_pkg::ST_FULL;
        end else begin
          cmd.op     = iidl_pkg::CELL_INSERT;
          cmd.at     = count[iidl_pkg::IDX_W-1:0];
          count_next = count + 1'b1;
        end
      end
      iidl_pkg::ACT_INSERT: begin
        // The range check takes precedence over the full check.
        if (s1_position > count) begin
          st_next = iidl_pkg::ST_BAD_INDEX;
        end else if (full) begin
          st_next = iidl_pkg::ST_FULL;
        end else begin
          cmd.op     = iidl_pkg::CELL_INSERT;
          count_next = count + 1'b1;
        end
      end
      iidl_pkg::ACT_DELETE: begin
        if (s1_position >= count) begin
          st_next = iidl_pkg::ST_BAD_INDEX;
        end else begin
          cmd.op     = iidl_pkg::CELL_DELETE;
          count_next = count - 1'b1;
        end
      end
      default: begin
        st_next = iidl_pkg::ST_BAD_INDEX;
      end
    endcase
    if (!s1_advance) begin
      cmd.op     = iidl_pkg::CELL_HOLD;
      count_next = count;
    end
  end

  iidl_cells u_cells (
    .clk      (clk),
    .cmd      (cmd),
    .rd_index (s1_position[iidl_pkg::IDX_W-1:0]),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      read_value <= rd_next;
      status     <= st_next;
      length     <= count_next;
    end
  end

  a_length_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length <= iidl_pkg::CNT_W'(iidl_pkg::CAPACITY))
    else $error("result length exceeds capacity");

  a_full_at_capacity: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == iidl_pkg::ST_FULL) |->
      length == iidl_pkg::CNT_W'(iidl_pkg::CAPACITY))
    else $error("full status reported below capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("count moved by more than one");

  a_count_needs_item: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> $past(s1_advance))
    else $error("count changed without an item completing");

endmodule
`default_nettype wire

### tb/tb_indexed_insert_delete_list.sv
// Testbench for the indexed insert/delete list: random and directed requests against a predictor.
`timescale 1ns / 100ps

module tb_indexed_insert_delete_list;

  localparam int ACT_UNDEF_LO = iidl_pkg::ACT_DELETE + 1;
  localparam int ACT_UNDEF_HI = 7;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASE_LEN    = 80;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 1100;
  localparam int IDLE_PCT     = 38;

  typedef struct {
    logic [2:0]         act;
    logic [6:0]         pos;
    logic signed [31:0] val;
  } list_request_t;

  typedef struct {
    logic signed [31:0]  value;
    iidl_pkg::status_t   st;
    logic [6:0]          len;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         action = '0;
  logic [6:0]         position = '0;
  logic signed [31:0] new_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [6:0]         length;

  list_request_t      request_q[$];
  list_result_t       expected_q[$];
  logic signed [31:0] shadow_entries [iidl_pkg::CAPACITY];
  int                 shadow_count = 0;
  int                 planned_count = 0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 in_taken = 1'b0;
  list_result_t       want, fresh;

  indexed_insert_delete_list u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .position   (position),
    .new_value  (new_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status),
    .length     (length)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit idle_now();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Applies one request to the shadow store and returns the result it should give.
  function automatic list_result_t apply_list_request(input logic [2:0] act,
                                                      input logic [6:0] pos,
                                                      input logic signed [31:0] val);
    list_result_t r;
    int           p;
    int           at;
    p       = int'(pos);
    at      = -1;
    r.value = '0;
    r.st    = iidl_pkg::ST_OK;
    case (act)
      iidl_pkg::ACT_GET: begin
        if (p < shadow_count) begin
          r.value = shadow_entries[p];
        end else begin
          r.st = iidl_pkg::ST_BAD_INDEX;
        end
      end
      iidl_pkg::ACT_HEAD, iidl_pkg::ACT_TAIL: begin
        if (shadow_count >= iidl_pkg::CAPACITY) begin
          r.st = iidl_pkg::ST_FULL;
        end else begin
          at = (act == iidl_pkg::ACT_HEAD) ? 0 : shadow_count;
        end
      end
      iidl_pkg::ACT_INSERT: begin
        if (p > shadow_count) begin
          r.st = iidl_pkg::ST_BAD_INDEX;
        end else if (shadow_count >= iidl_pkg::CAPACITY) begin
          r.st = iidl_pkg::ST_FULL;
        end else begin
          at = p;
        end
      end
      iidl_pkg::ACT_DELETE: begin
        if (p >= shadow_count) begin
          r.st = iidl_pkg::ST_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_count--;
        end
      end
      default: r.st = iidl_pkg::ST_BAD_INDEX;
    endcase
    // A successful add opens a gap at the chosen place and moves the rest up.
    if (at >= 0) begin
      for (int i = shadow_count; i > at; i--) begin
        shadow_entries[i] = shadow_entries[i - 1];
      end
      shadow_entries[at] = val;
      shadow_count++;
    end
    r.len = 7'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Queues a request and keeps a running count so that positions can be aimed in range.
  task automatic queue_item(input logic [2:0] act, input logic [6:0] pos,
                            input logic signed [31:0] val);
    list_request_t req;
    req.act = act;
    req.pos = pos;
    req.val = val;
    request_q.push_back(req);
    case (act)
      iidl_pkg::ACT_HEAD, iidl_pkg::ACT_TAIL: begin
        if (planned_count < iidl_pkg::CAPACITY) planned_count++;
      end
      iidl_pkg::ACT_INSERT: begin
        if (int'(pos) <= planned_count && planned_count < iidl_pkg::CAPACITY) planned_count++;
      end
      iidl_pkg::ACT_DELETE: begin
        if (int'(pos) < planned_count) planned_count--;
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (request_q.size() > 0 && !idle_now()) begin
        in_valid  <= 1'b1;
        action    <= request_q[0].act;
        position  <= request_q[0].pos;
        new_value <= request_q[0].val;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !idle_now();
  end

  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf(
            "result with no item outstanding: value %0d status %0d length %0d",
            read_value, status, length));
        end else begin
          want = expected_q.pop_front();
          if (read_value !== want.value) begin
            report_mismatch($sformatf("read_value got %0d, want %0d", read_value, want.value));
          end
          if (status !== want.st) begin
            report_mismatch($sformatf("status got %0d, want %s", status, want.st.name()));
          end
          if (length !== want.len) begin
            report_mismatch($sformatf("length got %0d, want %0d", length, want.len));
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh = apply_list_request(action, position, new_value);
        expected_q.push_back(fresh);
        void'(request_q.pop_front());
        in_taken = 1'b1;
      end
    end
  end

  initial begin
    logic [2:0] act;
    logic [6:0] pos;
    int         roll;
    int         add_pct;
    int         del_pct;

    // Empty store: every read, delete and insert past position zero is out of range.
    queue_item(iidl_pkg::ACT_GET, 7'd0, 32'sd5);
    queue_item(iidl_pkg::ACT_GET, 7'd127, 32'sd5);
    queue_item(iidl_pkg::ACT_DELETE, 7'd0, 32'sd5);
    queue_item(iidl_pkg::ACT_INSERT, 7'd1, 32'sd5);
    queue_item(iidl_pkg::ACT_INSERT, 7'd0, 32'sh8000_0000);
    queue_item(iidl_pkg::ACT_HEAD, 7'd99, 32'sh7FFF_FFFF);
    queue_item(iidl_pkg::ACT_TAIL, 7'd0, 32'sd0);
    queue_item(iidl_pkg::ACT_TAIL, 7'd127, -32'sd1);
    queue_item(iidl_pkg::ACT_INSERT, 7'd4, 32'sh1234_5678);
    queue_item(iidl_pkg::ACT_INSERT, 7'd2, 32'shA5A5_A5A5);
    queue_item(iidl_pkg::ACT_INSERT, 7'd127, 32'sd7);
    queue_item(iidl_pkg::ACT_GET, 7'd0, 32'sd0);
    queue_item(iidl_pkg::ACT_GET, 7'd5, 32'sd0);
    queue_item(iidl_pkg::ACT_GET, 7'd6, 32'sd0);
    queue_item(3'(ACT_UNDEF_LO), 7'd0, -32'sd1);
    queue_item(3'(ACT_UNDEF_LO + 1), 7'd1, -32'sd1);
    queue_item(3'(ACT_UNDEF_HI), 7'd127, -32'sd1);
    queue_item(iidl_pkg::ACT_DELETE, 7'd127, 32'sd0);
    queue_item(iidl_pkg::ACT_DELETE, 7'd2, 32'sd0);
    queue_item(iidl_pkg::ACT_DELETE, 7'd4, 32'sd0);
    queue_item(iidl_pkg::ACT_DELETE, 7'd0, 32'sd0);
    queue_item(iidl_pkg::ACT_GET, 7'd1, 32'sd0);

    // Phases lean towards growth, balance or shrinkage so the store runs full and empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_LEN) % 5)
        0, 1: begin
          add_pct = 70;
          del_pct = 10;
        end
        2: begin
          add_pct = 40;
          del_pct = 30;
        end
        default: begin
          add_pct = 10;
          del_pct = 65;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        act = 3'($urandom_range(iidl_pkg::ACT_HEAD, iidl_pkg::ACT_INSERT));
      end else if (roll < add_pct + del_pct) begin
        act = iidl_pkg::ACT_DELETE;
      end else if (roll < 95) begin
        act = iidl_pkg::ACT_GET;
      end else begin
        act = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
      end
      if ($urandom_range(0, 9) == 0) begin
        pos = 7'($urandom_range(0, 127));
      end else if (act == iidl_pkg::ACT_INSERT) begin
        pos = 7'($urandom_range(0, planned_count));
      end else if (planned_count > 0) begin
        pos = 7'($urandom_range(0, planned_count - 1));
      end else begin
        pos = '0;
      end
      queue_item(act, pos, pick_value());
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
